>>> rtl/core/ctc_gd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTC greedy decode package
// Shared widths, limits, result codes and control structs for the decoder.
// ----------------------------------------------------------------------------
package ctc_gd_pkg;

  // Limits of the decoder.
  localparam int MAX_CLASSES = 8192;
  localparam int MAX_STEPS   = 1024;
  localparam int LOGIT_WIDTH = 16;

  // Field and state widths.
  localparam int NCLS_W  = 14;
  localparam int CLASS_W = 13;
  localparam int COUNT_W = 11;
  localparam int SUM_W   = 27;

  // Widths of the averaging divide: the dividend is 2*|sum| + count and the
  // divisor is 2*count.
  localparam int DVD_W  = SUM_W + 1;
  localparam int DVS_W  = COUNT_W + 1;
  localparam int STEP_W = $clog2(DVD_W);

  typedef logic signed [LOGIT_WIDTH-1:0] logit_t;
  typedef logic        [NCLS_W-1:0]      ncls_t;
  typedef logic        [CLASS_W-1:0]     class_t;
  typedef logic        [COUNT_W-1:0]     count_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic        [DVD_W-1:0]       dividend_t;
  typedef logic        [DVS_W-1:0]       divisor_t;

  // Saturation bounds of the confidence sum, held in the widened add format.
  localparam logic signed [SUM_W:0] SUM_MAX = 28'sd67108863;
  localparam logic signed [SUM_W:0] SUM_MIN = -28'sd67108864;

  localparam ncls_t  NCLS_RESET = ncls_t'(MAX_CLASSES);
  localparam count_t COUNT_MAX  = count_t'(MAX_STEPS);

  // Result kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_AVG  = 1'b1;

  // Control into and status out of the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/ctc_gd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTC greedy decode channels
// Valid/ready channels for logits, results and the class count register.
// ----------------------------------------------------------------------------

// Logit channel: one class score per item.
interface ctc_gd_in_if;
  import ctc_gd_pkg::*;
  logic   valid;
  logic   ready;
  logit_t logit;
  logic   end_of_sequence;

  modport source (output valid, output logit, output end_of_sequence, input ready);
  modport sink   (input valid, input logit, input end_of_sequence, output ready);
endinterface

// Result channel: a decoded character or the closing average.
interface ctc_gd_out_if;
  import ctc_gd_pkg::*;
  logic   valid;
  logic   ready;
  logic   result_kind;
  class_t char_index;
  logit_t confidence;
  count_t char_total;
  logic   last;

  modport source (output valid, output result_kind, output char_index,
                  output confidence, output char_total, output last, input ready);
  modport sink   (input valid, input result_kind, input char_index,
                  input confidence, input char_total, input last, output ready);
endinterface

// Configuration channel: write data of the class count register.
interface ctc_gd_cfg_if;
  import ctc_gd_pkg::*;
  logic  valid;
  logic  ready;
  ncls_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ctc_gd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTC greedy decode divider
// Restoring divider, one quotient bit per cycle, for the sequence average.
// ----------------------------------------------------------------------------
module ctc_gd_div (
  input  logic                  clk,
  input  logic                  rst,
  input  ctc_gd_pkg::div_ctrl_t ctrl,
  input  ctc_gd_pkg::dividend_t dividend,
  input  ctc_gd_pkg::divisor_t  divisor,
  output ctc_gd_pkg::div_stat_t stat,
  output ctc_gd_pkg::dividend_t quotient
);
  import ctc_gd_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  divisor_t          dvs;
  divisor_t          rem;
  dividend_t         quo;

  logic [DVS_W:0]    trial;
  logic              fits;

  // One trial subtraction of the shifted remainder against the divisor.
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  // Sequencer: load on start, then one step per cycle until all bits are done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + STEP_W'(1);
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DVS_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DVS_W-1:0];
      end
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

>>> rtl/core/ctc_greedy_decode_unit.sv
// A character result appears in the output register the cycle after the
// logit that closes its time step. The unit takes one logit per cycle while
// the result register is free, except that after the end of a sequence the
// input stalls while the 28-step divider forms the average. Reset is
// synchronous and clears all sequence state; the class count returns to
// 8192.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTC greedy decode unit
// Streaming argmax over class logits with repeat and blank collapse, and a
// rounded average confidence at the end of each sequence.
// ----------------------------------------------------------------------------
module ctc_greedy_decode_unit (
  input  logic         clk,
  input  logic         rst,
  ctc_gd_in_if.sink    logits,
  ctc_gd_out_if.source results,
  ctc_gd_cfg_if.sink   cfg
);
  import ctc_gd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_AVG   = 4'b1000
  } state_t;

  state_t    state;
  ncls_t     class_count;
  class_t    class_position;
  logit_t    best_value;
  class_t    best_class;
  class_t    previous_class;
  sum_t      confidence_sum;
  count_t    emitted_count;
  logic      avg_neg;
  logit_t    avg_mag;

  logic      out_valid;
  logic      out_kind;
  class_t    out_index;
  logit_t    out_conf;
  count_t    out_total;
  logic      out_last;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  dividend_t div_dividend;
  divisor_t  div_divisor;
  dividend_t div_quotient;

  logic      out_free;
  logic      accept;
  ncls_t     eff_classes;
  logic      take_new;
  logit_t    nb_value;
  class_t    nb_class;
  ncls_t     pos_next;
  logic      close;
  logic      emit;
  logic signed [SUM_W:0] sum_add;
  sum_t      sum_next;
  logic [SUM_W:0] sum_abs;

  assign out_free     = !out_valid || results.ready;
  assign logits.ready = (state == ST_IDLE) && out_free;
  assign accept       = logits.valid && logits.ready;
  assign cfg.ready    = 1'b1;

  // Effective class count: zero acts as one, above the limit as the limit.
  always_comb begin
    if (class_count == '0) begin
      eff_classes = ncls_t'(1);
    end else if (class_count > NCLS_RESET) begin
      eff_classes = NCLS_RESET;
    end else begin
      eff_classes = class_count;
    end
  end

  // Running argmax and step close; a strictly greater logit wins.
  always_comb begin
    take_new = (class_position == '0) || (logits.logit > best_value);
    nb_value = take_new ? logits.logit : best_value;
    nb_class = take_new ? class_position : best_class;
    pos_next = {1'b0, class_position} + ncls_t'(1);
    close    = (pos_next >= eff_classes) || logits.end_of_sequence;
    emit     = close && (nb_class != '0) && (nb_class != previous_class);
  end

  // Saturating confidence sum.
  always_comb begin
    sum_add = {confidence_sum[SUM_W-1], confidence_sum}
            + {{(SUM_W + 1 - LOGIT_WIDTH){nb_value[LOGIT_WIDTH-1]}}, nb_value};
    if (sum_add > SUM_MAX) begin
      sum_next = SUM_W'(SUM_MAX);
    end else if (sum_add < SUM_MIN) begin
      sum_next = SUM_W'(SUM_MIN);
    end else begin
      sum_next = sum_add[SUM_W-1:0];
    end
  end

  // Divide operands: round to nearest by (2|sum| + n) / 2n.
  always_comb begin
    sum_abs      = confidence_sum[SUM_W-1]
                 ? -{confidence_sum[SUM_W-1], confidence_sum}
                 : {1'b0, confidence_sum};
    div_dividend = DVD_W'({sum_abs[SUM_W-1:0], 1'b0}) + DVD_W'(emitted_count);
    div_divisor  = {emitted_count, 1'b0};
    div_ctrl.start = (state == ST_START) && (emitted_count != '0);
  end

  ctc_gd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  // Class count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= NCLS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      class_count <= cfg.data;
    end
  end

  // Sequencer and sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      class_position <= '0;
      best_value     <= '0;
      best_class     <= '0;
      previous_class <= '0;
      confidence_sum <= '0;
      emitted_count  <= '0;
      avg_neg        <= 1'b0;
      avg_mag        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (close) begin
              previous_class <= nb_class;
              class_position <= '0;
              best_value     <= '0;
              best_class     <= '0;
            end else begin
              class_position <= pos_next[CLASS_W-1:0];
              best_value     <= nb_value;
              best_class     <= nb_class;
            end
            if (emit && (emitted_count < COUNT_MAX)) begin
              emitted_count  <= emitted_count + count_t'(1);
              confidence_sum <= sum_next;
            end
            if (logits.end_of_sequence) begin
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          avg_neg <= confidence_sum[SUM_W-1];
          if (emitted_count == '0) begin
            avg_mag <= '0;
            state   <= ST_AVG;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            avg_mag <= div_quotient[LOGIT_WIDTH-1:0];
            state   <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (out_free) begin
            class_position <= '0;
            best_value     <= '0;
            best_class     <= '0;
            previous_class <= '0;
            confidence_sum <= '0;
            emitted_count  <= '0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: valid flag under reset, payload loaded when an item forms.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_IDLE) && accept && emit) begin
      out_valid <= 1'b1;
    end else if ((state == ST_AVG) && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept && emit) begin
      out_kind  <= KIND_CHAR;
      out_index <= nb_class - class_t'(1);
      out_conf  <= '0;
      out_total <= '0;
      out_last  <= 1'b0;
    end else if ((state == ST_AVG) && out_free) begin
      out_kind  <= KIND_AVG;
      out_index <= '0;
      out_conf  <= avg_neg ? -avg_mag : avg_mag;
      out_total <= emitted_count;
      out_last  <= 1'b1;
    end
  end

  assign results.valid       = out_valid;
  assign results.result_kind = out_kind;
  assign results.char_index  = out_index;
  assign results.confidence  = out_conf;
  assign results.char_total  = out_total;
  assign results.last        = out_last;

endmodule

>>> rtl/core/ctc_gd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CTC greedy decode checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ctc_gd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_eos,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_kind,
  input ctc_gd_pkg::logit_t  out_conf,
  input ctc_gd_pkg::count_t  out_total,
  input logic                out_last
);
  import ctc_gd_pkg::*;

  // The final item of a sequence is always the average, and only it.
  a_last_is_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind == KIND_AVG)))
    else $error("last flag does not match the average item");

  // A character item carries no confidence and no count.
  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_CHAR)) |-> ((out_conf == '0) && (out_total == '0)))
    else $error("character item carries average fields");

  // The character count never passes its limit.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_AVG)) |-> (out_total <= COUNT_MAX))
    else $error("character count beyond its limit");

  // The average is being formed after an end of sequence: input stalls.
  a_eos_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_eos) |=> !in_ready)
    else $error("input taken while the average is pending");

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result item withdrawn while stalled");

endmodule

bind ctc_greedy_decode_unit ctc_gd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (logits.valid),
  .in_ready  (logits.ready),
  .in_eos    (logits.end_of_sequence),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_kind  (results.result_kind),
  .out_conf  (results.confidence),
  .out_total (results.char_total),
  .out_last  (results.last)
);
